/* sv/gns_pkg.sv */
package gns_pkg;

    // Grid dimensions and cell width of the store.
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int VALUE_BITS = 16;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int COL_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ADDR_BITS  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Nine cells summed need four bits of headroom.
    localparam int ACC_BITS   = VALUE_BITS + 4;

    // Fixed port widths.
    localparam int CFG_BITS       = 7;
    localparam int CFG_INDEX_BITS = 1;
    localparam int COORD_BITS     = 6;
    localparam int IN_VALUE_BITS  = 16;
    localparam int SUM_BITS       = 20;

    localparam logic [63:0] SUM_MAX = (64'd1 << SUM_BITS) - 64'd1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 1'b1;

    localparam logic [CFG_BITS-1:0] GRID_WIDTH_RESET  = 7'd64;
    localparam logic [CFG_BITS-1:0] GRID_HEIGHT_RESET = 7'd64;

    // Transaction kinds.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Offset of a neighbour from the centre along one axis.
    typedef enum logic [1:0] {
        OFS_MINUS = 2'd0,
        OFS_ZERO  = 2'd1,
        OFS_PLUS  = 2'd2
    } ofs_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_en;
        logic write_en;
        logic query_start;
        logic read_en;
        ofs_t col_ofs;
        ofs_t row_ofs;
        logic finish;
    } gns_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
    } gns_status_t;

    // Last index in use along one axis: zero counts as one, and a span
    // above the limit counts as the limit.
    function automatic int span_last(logic [CFG_BITS-1:0] span, int limit);
        int res;
        if (span == '0)
            res = 0;
        else if (int'(span) > limit)
            res = limit - 1;
        else
            res = int'(span) - 1;
        return res;
    endfunction

    // Neighbour position along one axis, clamped to the grid in use.
    function automatic int step_clamp(int pos, ofs_t ofs, int last);
        int res;
        unique case (ofs)
            OFS_MINUS: res = (pos == 0) ? 0 : pos - 1;
            OFS_PLUS:  res = (pos >= last) ? last : pos + 1;
            default:   res = pos;
        endcase
        return res;
    endfunction

    // Offset sequence minus, zero, plus, then round again.
    function automatic ofs_t next_ofs(ofs_t ofs);
        ofs_t res;
        unique case (ofs)
            OFS_MINUS: res = OFS_ZERO;
            OFS_ZERO:  res = OFS_PLUS;
            default:   res = OFS_MINUS;
        endcase
        return res;
    endfunction

endpackage

/* sv/gns_ctrl.sv */
module gns_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 action,
    input  gns_pkg::gns_status_t status,
    output gns_pkg::gns_cmd_t    cmd,
    output logic                 busy
);
    import gns_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    ofs_t   col_ofs_reg, col_ofs_next;
    ofs_t   row_ofs_reg, row_ofs_next;
    logic   accept;
    logic   last_tap;

    assign accept   = start && (state_reg == S_IDLE);
    assign last_tap = (col_ofs_reg == OFS_PLUS) && (row_ofs_reg == OFS_PLUS);

    always_comb
    begin
        state_next   = state_reg;
        col_ofs_next = col_ofs_reg;
        row_ofs_next = row_ofs_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                col_ofs_next = OFS_MINUS;
                row_ofs_next = OFS_MINUS;
                if (accept && (action == ACT_QUERY))
                    state_next = S_READ;
            end
            S_READ:
            begin
                col_ofs_next = next_ofs(col_ofs_reg);
                if (col_ofs_reg == OFS_PLUS)
                    row_ofs_next = next_ofs(row_ofs_reg);
                if (last_tap)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            col_ofs_reg <= OFS_MINUS;
            row_ofs_reg <= OFS_MINUS;
        end
        else
        begin
            state_reg   <= state_next;
            col_ofs_reg <= col_ofs_next;
            row_ofs_reg <= row_ofs_next;
        end
    end

    always_comb
    begin
        cmd.clear_en    = (state_reg == S_CLEAR);
        cmd.write_en    = accept && (action == ACT_WRITE);
        cmd.query_start = accept && (action == ACT_QUERY);
        cmd.read_en     = (state_reg == S_READ);
        cmd.col_ofs     = col_ofs_reg;
        cmd.row_ofs     = row_ofs_reg;
        cmd.finish      = (state_reg == S_DRAIN);
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* sv/gns_datapath.sv */
module gns_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [gns_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [gns_pkg::CFG_BITS-1:0]          cfg_wdata,
    input  logic [gns_pkg::COORD_BITS-1:0]        cell_x,
    input  logic [gns_pkg::COORD_BITS-1:0]        cell_y,
    input  logic [gns_pkg::IN_VALUE_BITS-1:0]     cell_value,
    input  gns_pkg::gns_cmd_t                     cmd,
    output gns_pkg::gns_status_t                  status,
    output logic [gns_pkg::SUM_BITS-1:0]          neighbourhood_sum,
    output logic                                  result_valid
);
    import gns_pkg::*;

    logic [VALUE_BITS-1:0] mem [STORE_DEPTH];

    logic [CFG_BITS-1:0]   grid_width_reg, grid_height_reg;
    logic [COL_BITS-1:0]   col_last, in_col, tap_col, cx_reg;
    logic [ROW_BITS-1:0]   row_last, in_row, tap_row, cy_reg;
    logic [ADDR_BITS-1:0]  clr_addr_reg, mem_addr;
    logic                  mem_we;
    logic [VALUE_BITS-1:0] mem_wdata, rd_data_reg;
    logic                  rd_valid_reg, rd_centre_reg, centre_big_reg;
    logic [ACC_BITS-1:0]   acc_reg, acc_sum;
    logic [SUM_BITS-1:0]   sum_final, sum_reg;
    logic                  result_valid_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RESET;
            grid_height_reg <= GRID_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata;
                default:         grid_height_reg <= cfg_wdata;
            endcase
        end
    end

    assign col_last = COL_BITS'(span_last(grid_width_reg, MAX_WIDTH));
    assign row_last = ROW_BITS'(span_last(grid_height_reg, MAX_HEIGHT));

    // Incoming coordinates clamped to the grid in use.
    assign in_col = (int'(cell_x) > int'(col_last)) ? col_last : COL_BITS'(cell_x);
    assign in_row = (int'(cell_y) > int'(row_last)) ? row_last : ROW_BITS'(cell_y);

    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            cx_reg <= in_col;
            cy_reg <= in_row;
        end
    end

    assign tap_col = COL_BITS'(step_clamp(int'(cx_reg), cmd.col_ofs, int'(col_last)));
    assign tap_row = ROW_BITS'(step_clamp(int'(cy_reg), cmd.row_ofs, int'(row_last)));

    // Single port of the cell store.
    always_comb
    begin
        mem_we    = cmd.clear_en || cmd.write_en;
        mem_wdata = cmd.clear_en ? '0 : VALUE_BITS'(cell_value);
        priority if (cmd.clear_en)
            mem_addr = clr_addr_reg;
        else if (cmd.write_en)
            mem_addr = ADDR_BITS'(int'(in_row) * MAX_WIDTH + int'(in_col));
        else
            mem_addr = ADDR_BITS'(int'(tap_row) * MAX_WIDTH + int'(tap_col));
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_data_reg <= mem[mem_addr];
    end

    // Clearing sweep after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clear_en && !status.clear_last)
            clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
    end

    assign status.clear_last = (clr_addr_reg == ADDR_BITS'(STORE_DEPTH - 1));

    // Accumulation of the nine taps from the registered read data.
    assign acc_sum = acc_reg + ACC_BITS'(rd_data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg     <= 1'b0;
            rd_centre_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg     <= cmd.read_en;
            rd_centre_reg    <= cmd.read_en && (cmd.col_ofs == OFS_ZERO)
                                && (cmd.row_ofs == OFS_ZERO);
            result_valid_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
            acc_reg <= '0;
        else if (rd_valid_reg)
            acc_reg <= acc_sum;
        if (rd_centre_reg)
            centre_big_reg <= (rd_data_reg > VALUE_BITS'(1));
    end

    always_comb
    begin
        if (!centre_big_reg)
            sum_final = '0;
        else if (64'(acc_sum) > SUM_MAX)
            sum_final = '1;
        else
            sum_final = SUM_BITS'(acc_sum);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            sum_reg <= sum_final;
    end

    assign neighbourhood_sum = sum_reg;
    assign result_valid      = result_valid_reg;

endmodule

/* sv/grid_neighbourhood_sum.sv */
// Channel        Handshake              Payload
// ------------   --------------------   ---------------------------------------
// input          start high, busy low   action, cell_x, cell_y, cell_value
// result         result_valid strobe    neighbourhood_sum
// configuration  cfg_we                 cfg_index, cfg_wdata
//
// After reset the block sweeps all MAX_WIDTH * MAX_HEIGHT cells of the store to
// zero, one cell per cycle; busy stays high meanwhile.
// A write transaction stores the cell at the accepting edge.
// In a query transaction the store has a single port, so the nine
// neighbourhood cells are read one per cycle, then a drain state finishes
// the sum. The result is shown in the cycle after, while busy is already low,
// so the next transaction may be accepted in the same cycle as the result.
// The receiver cannot stall: result_valid is high for one cycle only.
module grid_neighbourhood_sum (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [gns_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [gns_pkg::CFG_BITS-1:0]       cfg_wdata,
    // Input transactions.
    input  logic                               start,
    output logic                               busy,
    input  logic                               action,
    input  logic [gns_pkg::COORD_BITS-1:0]     cell_x,
    input  logic [gns_pkg::COORD_BITS-1:0]     cell_y,
    input  logic [gns_pkg::IN_VALUE_BITS-1:0]  cell_value,
    // Result transactions.
    output logic                               result_valid,
    output logic [gns_pkg::SUM_BITS-1:0]       neighbourhood_sum
);
    import gns_pkg::*;

    // The controller sequences the clearing sweep, the nine neighbourhood
    // reads and the final summing cycle; the datapath owns the cell store,
    // the coordinate clamping, the accumulator and the result register.
    gns_cmd_t    cmd;
    gns_status_t status;

    gns_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    gns_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .cell_x            (cell_x),
        .cell_y            (cell_y),
        .cell_value        (cell_value),
        .cmd               (cmd),
        .status            (status),
        .neighbourhood_sum (neighbourhood_sum),
        .result_valid      (result_valid)
    );

endmodule

/* sv/gns_checker.sv */
module gns_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic action,
    input logic result_valid
);
    import gns_pkg::*;

    // A query occupies the block from the cycle after it is accepted.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_QUERY)) |=> busy)
        else $error("query accepted but block not busy");

    // A write completes at once and leaves the block free.
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_WRITE)) |=> !busy)
        else $error("write transaction left the block busy");

    // A result only ever follows a busy cycle.
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without preceding query work");

    // Results are single-cycle strobes.
    a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for more than one cycle");

endmodule

bind grid_neighbourhood_sum gns_checker u_gns_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .result_valid (result_valid)
);
